FILE: sv/dcw_pkg.sv
// shared types and constants of the dds command word decoder
// no dependencies; imported by every module of the block
package dcw_pkg;

    // accumulator and output phase sizing
    localparam int ACC_BITS        = 28;
    localparam int PHASE_BITS      = 12;
    localparam int FREQ_BITS       = 28;
    localparam int HALF_BITS       = 14;
    localparam int PHASE_WORD_BITS = 12;
    localparam int OUT_PHASE_BITS  = 12;
    localparam int WORD_BITS       = 16;
    localparam int FREQ_EXT_BITS   = 32;
    localparam int OFF_PAD_BITS    = 16;
    localparam int OFF_EXT_BITS    = PHASE_WORD_BITS + OFF_PAD_BITS;
    localparam int SUM_EXT_BITS    = 32;

    // control register keeps its bits at their word positions
    localparam int CTL_BITS = 14;
    localparam logic [CTL_BITS-1:0] CTL_MASK = 14'h3DAA;
    localparam int CTL_B28     = 13;
    localparam int CTL_HLB     = 12;
    localparam int CTL_FSEL    = 11;
    localparam int CTL_PSEL    = 10;
    localparam int CTL_RESET   = 8;
    localparam int CTL_SLEEP1  = 7;
    localparam int CTL_OPBITEN = 5;
    localparam int CTL_DIV2    = 3;
    localparam int CTL_MODE    = 1;

    // command word field positions
    localparam int WORD_PHASE_SEL = 12;

    // item kind on the cmd field
    localparam logic CMD_TICK = 1'b1;

    // queue depths
    localparam int OPQ_DEPTH  = 4;
    localparam int OPQ_PTR_W  = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W  = $clog2(OPQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

    // wave mode codes
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SQUARE   = 2'd2;

    // routing field of a command word
    typedef enum logic [1:0] {
        ROUTE_CTRL  = 2'b00,
        ROUTE_FREQ0 = 2'b01,
        ROUTE_FREQ1 = 2'b10,
        ROUTE_PHASE = 2'b11
    } route_t;

    // decoded operation kinds
    typedef enum logic [1:0] {
        OP_TICK,
        OP_CTRL,
        OP_FREQ,
        OP_PHASE
    } op_kind_t;

    typedef struct packed {
        logic                 cmd;
        logic [WORD_BITS-1:0] word;
    } item_t;

    typedef struct packed {
        logic [OUT_PHASE_BITS-1:0] out_phase;
        logic [1:0]                wave_mode;
        logic                      square_bit;
        logic                      in_reset;
    } result_t;

    // decoded operation handed from front to back
    typedef struct packed {
        op_kind_t             kind;
        logic                 index;
        logic [HALF_BITS-1:0] data;
    } op_t;

endpackage

FILE: sv/dds_command_word_decoder.sv
// Device side of a DDS serial word interface with a 28-bit phase accumulator. Each
// transaction is a 16-bit command word or one master clock tick, and each yields one
// result: output phase, wave mode, square bit and the reset flag. The block sustains
// one transaction per cycle while full is low; a transaction passes one register stage
// in the operation queue and one in the result buffer, and the execute stage between
// them is combinational, with the frequency add into the accumulator and the phase
// offset add both done there. A four-entry operation queue and a two-entry result
// buffer absorb stalls on either side.
// top level; depends on dcw_pkg, dcw_front, dcw_op_queue and dcw_back
module dds_command_word_decoder (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  dcw_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output dcw_pkg::result_t result
);
    import dcw_pkg::*;

    op_t  dec_op;
    op_t  q_op;
    logic q_valid;
    logic q_take;

    // decode incoming transactions
    dcw_front u_front (
        .item (item),
        .op   (dec_op)
    );

    // queue between decode and execute
    dcw_op_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (push),
        .wr_op (dec_op),
        .full  (full),
        .rd_en (q_take),
        .valid (q_valid),
        .rd_op (q_op)
    );

    // execute and buffer results
    dcw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (q_valid),
        .op       (q_op),
        .op_take  (q_take),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

FILE: sv/dcw_front.sv
// front end: classifies an incoming transaction into a decoded operation
// depends on dcw_pkg
module dcw_front (
    input  dcw_pkg::item_t item,
    output dcw_pkg::op_t   op
);
    import dcw_pkg::*;

    route_t route;

    // route on the top two bits, ticks bypass the word
    always_comb
    begin
        route    = route_t'(item.word[WORD_BITS-1 -: 2]);
        op.kind  = OP_TICK;
        op.index = 1'b0;
        op.data  = '0;
        if (item.cmd == CMD_TICK)
        begin
            op.kind = OP_TICK;
        end
        else
        begin
            case (route)
                ROUTE_CTRL:
                begin
                    op.kind = OP_CTRL;
                    op.data = item.word[HALF_BITS-1:0] & CTL_MASK;
                end
                ROUTE_FREQ0, ROUTE_FREQ1:
                begin
                    op.kind  = OP_FREQ;
                    op.index = (route == ROUTE_FREQ1);
                    op.data  = item.word[HALF_BITS-1:0];
                end
                ROUTE_PHASE:
                begin
                    op.kind  = OP_PHASE;
                    op.index = item.word[WORD_PHASE_SEL];
                    op.data  = HALF_BITS'(item.word[PHASE_WORD_BITS-1:0]);
                end
                default:
                begin
                    op.kind = OP_TICK;
                end
            endcase
        end
    end

endmodule

FILE: sv/dcw_op_queue.sv
// short queue of decoded operations between front and back
// depends on dcw_pkg
module dcw_op_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  dcw_pkg::op_t wr_op,
    output logic         full,
    input  logic         rd_en,
    output logic         valid,
    output dcw_pkg::op_t rd_op
);
    import dcw_pkg::*;

    op_t                  slot_reg [OPQ_DEPTH];
    logic [OPQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OPQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OPQ_CNT_W-1:0] count_reg, count_next;
    logic                 do_wr, do_rd;

    assign full  = (count_reg == OPQ_CNT_W'(OPQ_DEPTH));
    assign valid = (count_reg != '0);
    assign rd_op = slot_reg[rd_ptr_reg];
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && valid;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage slots
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

FILE: sv/dcw_back.sv
// back end: register file, phase accumulator and result buffer
// depends on dcw_pkg
module dcw_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            op_valid,
    input  dcw_pkg::op_t    op,
    output logic            op_take,
    input  logic            pop,
    output logic            empty,
    output dcw_pkg::result_t result
);
    import dcw_pkg::*;

    // architectural state
    logic [CTL_BITS-1:0]        ctl_reg, ctl_next;
    logic [FREQ_BITS-1:0]       freq_reg [2];
    logic [FREQ_BITS-1:0]       freq_next [2];
    logic [PHASE_WORD_BITS-1:0] phase_reg [2];
    logic [PHASE_WORD_BITS-1:0] phase_next [2];
    logic                       pend_reg, pend_next;
    logic [HALF_BITS-1:0]       hold_reg, hold_next;
    logic [ACC_BITS-1:0]        acc_reg, acc_next;
    logic                       msb_prev_reg, msb_prev_next;
    logic                       toggle_reg, toggle_next;

    // result buffer
    result_t                 res_slot_reg [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0]   res_wr_reg, res_wr_next;
    logic [RESQ_PTR_W-1:0]   res_rd_reg, res_rd_next;
    logic [RESQ_CNT_W-1:0]   res_cnt_reg, res_cnt_next;

    logic                       pop_take;
    logic                       room;
    logic [FREQ_EXT_BITS-1:0]   freq_ext;
    logic                       msb;
    logic [OFF_EXT_BITS-1:0]    off_ext;
    logic [PHASE_BITS-1:0]      top;
    logic [PHASE_BITS-1:0]      sum;
    logic [SUM_EXT_BITS-1:0]    sum_ext;
    result_t                    res_new;

    assign empty    = (res_cnt_reg == '0);
    assign result   = res_slot_reg[res_rd_reg];
    assign pop_take = pop && !empty;
    assign room     = (res_cnt_reg != RESQ_CNT_W'(RESQ_DEPTH)) || pop_take;
    assign op_take  = op_valid && room;
    assign freq_ext = FREQ_EXT_BITS'(freq_reg[ctl_reg[CTL_FSEL]]);

    // execute one operation against the register file
    always_comb
    begin
        ctl_next      = ctl_reg;
        freq_next     = freq_reg;
        phase_next    = phase_reg;
        pend_next     = pend_reg;
        hold_next     = hold_reg;
        acc_next      = acc_reg;
        if (op_take)
        begin
            case (op.kind)
                OP_TICK:
                begin
                    if (ctl_reg[CTL_RESET])
                    begin
                        acc_next = '0;
                    end
                    else if (!ctl_reg[CTL_SLEEP1])
                    begin
                        acc_next = acc_reg + freq_ext[ACC_BITS-1:0];
                    end
                end
                OP_CTRL:
                begin
                    ctl_next  = op.data;
                    pend_next = 1'b0;
                    if (op.data[CTL_RESET])
                    begin
                        acc_next = '0;
                    end
                end
                OP_PHASE:
                begin
                    phase_next[op.index] = op.data[PHASE_WORD_BITS-1:0];
                end
                OP_FREQ:
                begin
                    if (ctl_reg[CTL_B28])
                    begin
                        if (!pend_reg)
                        begin
                            hold_next = op.data;
                            pend_next = 1'b1;
                        end
                        else
                        begin
                            freq_next[op.index] = {op.data, hold_reg};
                            pend_next           = 1'b0;
                        end
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        if (ctl_reg[CTL_HLB])
                        begin
                            freq_next[op.index][FREQ_BITS-1:HALF_BITS] = op.data;
                        end
                        else
                        begin
                            freq_next[op.index][HALF_BITS-1:0] = op.data;
                        end
                    end
                end
                default:
                begin
                    pend_next = pend_reg;
                end
            endcase
        end
    end

    // msb edge tracking and output formatting from the updated state
    always_comb
    begin
        msb           = acc_next[ACC_BITS-1];
        msb_prev_next = msb_prev_reg;
        toggle_next   = toggle_reg;
        if (op_take)
        begin
            msb_prev_next = msb;
            toggle_next   = toggle_reg ^ (msb && !msb_prev_reg);
        end
        off_ext = {phase_next[ctl_next[CTL_PSEL]], OFF_PAD_BITS'(0)};
        top     = acc_next[ACC_BITS-1 -: PHASE_BITS];
        sum     = top + off_ext[OFF_EXT_BITS-1 -: PHASE_BITS];
        sum_ext = SUM_EXT_BITS'(sum);
        res_new.out_phase = sum_ext[OUT_PHASE_BITS-1:0];
        if (ctl_next[CTL_OPBITEN])
        begin
            res_new.wave_mode  = WAVE_SQUARE;
            res_new.square_bit = ctl_next[CTL_DIV2] ? msb : toggle_next;
        end
        else
        begin
            res_new.wave_mode  = ctl_next[CTL_MODE] ? WAVE_TRIANGLE : WAVE_SINE;
            res_new.square_bit = 1'b0;
        end
        res_new.in_reset = ctl_next[CTL_RESET];
    end

    // result buffer pointers
    always_comb
    begin
        res_wr_next  = res_wr_reg;
        res_rd_next  = res_rd_reg;
        res_cnt_next = res_cnt_reg;
        if (op_take)
        begin
            res_wr_next = (res_wr_reg == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : res_wr_reg + 1'b1;
        end
        if (pop_take)
        begin
            res_rd_next = (res_rd_reg == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : res_rd_reg + 1'b1;
        end
        if (op_take && !pop_take)
        begin
            res_cnt_next = res_cnt_reg + 1'b1;
        end
        else if (pop_take && !op_take)
        begin
            res_cnt_next = res_cnt_reg - 1'b1;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg      <= '0;
            freq_reg[0]  <= '0;
            freq_reg[1]  <= '0;
            phase_reg[0] <= '0;
            phase_reg[1] <= '0;
            pend_reg     <= 1'b0;
            hold_reg     <= '0;
            acc_reg      <= '0;
            msb_prev_reg <= 1'b0;
            toggle_reg   <= 1'b0;
            res_wr_reg   <= '0;
            res_rd_reg   <= '0;
            res_cnt_reg  <= '0;
        end
        else
        begin
            ctl_reg      <= ctl_next;
            freq_reg     <= freq_next;
            phase_reg    <= phase_next;
            pend_reg     <= pend_next;
            hold_reg     <= hold_next;
            acc_reg      <= acc_next;
            msb_prev_reg <= msb_prev_next;
            toggle_reg   <= toggle_next;
            res_wr_reg   <= res_wr_next;
            res_rd_reg   <= res_rd_next;
            res_cnt_reg  <= res_cnt_next;
        end
    end

    // result slots
    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            res_slot_reg[res_wr_reg] <= res_new;
        end
    end

endmodule

FILE: sv/dcw_checker.sv
// port-level checks of the dds command word decoder, bound to the top level
// depends on dcw_pkg
module dcw_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             push,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input dcw_pkg::result_t result
);
    import dcw_pkg::*;

    localparam int OUTST_MAX = OPQ_DEPTH + RESQ_DEPTH;
    localparam int OUTST_W   = $clog2(OUTST_MAX + 1) + 1;

    logic [OUTST_W-1:0] outst_reg, outst_next;
    logic               in_take, out_take;

    assign in_take  = push && !full;
    assign out_take = pop && !empty;

    // transactions accepted but not yet delivered
    always_comb
    begin
        outst_next = outst_reg;
        if (in_take && !out_take)
        begin
            outst_next = outst_reg + 1'b1;
        end
        else if (out_take && !in_take)
        begin
            outst_next = outst_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
        end
        else
        begin
            outst_reg <= outst_next;
        end
    end

    // never more in flight than the queues hold, never a result without a transaction
    a_outst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outst_reg <= OUTST_W'(OUTST_MAX))
        else $error("in-flight count out of range");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (outst_reg == '0) |-> empty)
        else $error("result shown with nothing outstanding");

    // square bit only in square mode
    a_square_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.wave_mode != WAVE_SQUARE) |-> !result.square_bit)
        else $error("square bit set outside square mode");

    // a waiting result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

endmodule

bind dds_command_word_decoder dcw_checker u_dcw_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
